FILE: rtl/core/msp_pkg.sv
package msp_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic [31:0] z_in;
    logic        last_vertex;
  } in_t;

  typedef struct packed {
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [31:0] z_out;
    logic        at_center;
  } out_t;

  // Item class decided by the front part.
  typedef enum logic [1:0] {
    OP_ACC      = 2'd0,
    OP_ACC_LAST = 2'd1,
    OP_XFORM    = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } cmd_t;

  // Configuration register indexes.
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_PAD   = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) begin
      r = SAT_MAX;
    end else if (v < -50'sd2147483648) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mesh_scale_and_pad.sv
// Moves mesh vertices away from their centroid by a scale and a padding.
// Send the vertices twice on the input channel (in_valid, in_stall, in_data).
// In the first pass, accumulate items (command 0) add to running sums and
// the item with last_vertex set latches the rounded centroid. In the second
// pass, each transform item (command 1) returns one result item on the output
// channel (out_valid, out_stall, out_data); accumulate items return nothing.
// Items pass a registered front stage and a four-entry queue before the back
// part, which works on one item at a time. An accumulate item is taken in
// the idle state; a last mark then occupies the back part for the load, the
// 49-step restoring division of the centroid and its saturation. A transform
// item occupies it chiefly for the 34-step bit-serial square root of the
// offset length and the 31-step division (after a load) for the unit
// direction; a vertex on the centroid skips both. The input side keeps
// accepting until the queue and the front stage are full. A stalled result
// holds in the output register while the next item is already at work.
// Synchronous reset clears sums, count and centroid to zero and sets the
// scale to 1.0 and the padding to 0. Write cfg registers only when idle.
module mesh_scale_and_pad #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  msp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output msp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata
);

  logic [23:0]        scale_r;
  logic signed [31:0] pad_r;

  logic          push_valid;
  logic          push_ready;
  msp_pkg::cmd_t push_item;
  logic          pop_valid;
  logic          pop;
  msp_pkg::cmd_t pop_item;

  // Configuration registers; there is no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 24'd65536;
      pad_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msp_pkg::REG_SCALE: scale_r <= cfg_wdata[23:0];
        msp_pkg::REG_PAD:   pad_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Front: takes items in and classifies them.
  msp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue decouples the front from the back.
  msp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // Back: sums, centroid division and the vertex transform.
  msp_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_item    (pop_item),
    .q_pop     (pop),
    .scale     (scale_r),
    .pad       (pad_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/msp_front.sv
module msp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  msp_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output msp_pkg::cmd_t push_item
);

  logic          fv_r;
  msp_pkg::cmd_t item_r;
  logic          accept;

  assign in_stall   = fv_r && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = fv_r;
  assign push_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (accept) begin
      fv_r <= 1'b1;
    end else if (push_ready) begin
      fv_r <= 1'b0;
    end
  end

  // Classify the item; the last mark only matters on an accumulate.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_data.command) begin
        item_r.op <= msp_pkg::OP_XFORM;
      end else if (in_data.last_vertex) begin
        item_r.op <= msp_pkg::OP_ACC_LAST;
      end else begin
        item_r.op <= msp_pkg::OP_ACC;
      end
      item_r.x <= in_data.x_in;
      item_r.y <= in_data.y_in;
      item_r.z <= in_data.z_in;
    end
  end

endmodule

FILE: rtl/core/msp_queue.sv
module msp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  msp_pkg::cmd_t push_item,
  output logic          pop_valid,
  input  logic          pop,
  output msp_pkg::cmd_t pop_item
);

  msp_pkg::cmd_t                 mem_r [msp_pkg::QUEUE_DEPTH];
  logic [msp_pkg::QPTR_W-1:0]    wr_r;
  logic [msp_pkg::QPTR_W-1:0]    rd_r;
  logic [msp_pkg::QPTR_W:0]      cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = cnt_r != (msp_pkg::QPTR_W + 1)'(msp_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/msp_back.sv
module msp_back #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  msp_pkg::cmd_t      q_item,
  output logic               q_pop,
  input  logic [23:0]        scale,
  input  logic signed [31:0] pad,
  output logic               out_valid,
  input  logic               out_stall,
  output msp_pkg::out_t      out_data
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_SQRT, S_DIV, S_MS, S_MP, S_SUM, S_OUT,
    S_CLOAD, S_CDIV, S_CSAT
  } state_t;

  state_t              state_r;
  logic [5:0]          step_r;
  logic [47:0]         sum_r   [3];
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cdiv_r;
  logic signed [31:0]  ctr_r   [3];
  logic signed [32:0]  d_r     [3];
  logic [65:0]         acc_r;
  logic [65:0]         mul_r;
  logic [65:0]         sq_rem_r;
  logic [67:0]         res_r;
  logic [66:0]         bit_r;
  logic [33:0]         norm_r;
  logic [34:0]         drem_r  [3];
  logic [30:0]         quo_r   [3];
  logic [40:0]         s_r     [3];
  logic [32:0]         p_r     [3];
  logic [48:0]         cdd_r   [3];
  logic                cneg_r  [3];
  logic [CNT_W-1:0]    crem_r  [3];
  logic [48:0]         cq_r    [3];
  msp_pkg::out_t       o_r;
  logic                out_valid_r;
  msp_pkg::out_t       out_data_r;

  logic [32:0]         ad       [3];
  logic [31:0]         in_c     [3];
  logic [31:0]         apad;
  logic [1:0]          ax;
  logic [1:0]          cx;
  logic [32:0]         mul_a;
  logic [32:0]         mul_b;
  logic [65:0]         mul_p;
  logic [67:0]         sq_t;
  logic                sq_ge;
  logic                out_free;
  logic [CNT_W-1:0]    cnt_inc;
  logic                cnt_room;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_c[0]   = q_item.x;
  assign in_c[1]   = q_item.y;
  assign in_c[2]   = q_item.z;
  assign apad      = pad[31] ? 32'(-pad) : pad;
  assign cnt_room  = cnt_r < CNT_W'(MAX_VERTICES);
  assign cnt_inc   = cnt_r + 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad[i] = d_r[i][32] ? 33'(-d_r[i]) : 33'(d_r[i]);
    end
  end

  // Axis fed to the shared multiplier and axis whose product is consumed.
  assign ax = (step_r[1:0] == 2'd3) ? 2'd2 : step_r[1:0];
  assign cx = (step_r[1:0] == 2'd0) ? 2'd0 : step_r[1:0] - 2'd1;

  always_comb begin
    unique case (state_r)
      S_MS: begin
        mul_a = ad[ax];
        mul_b = {9'd0, scale};
      end
      S_MP: begin
        mul_a = {2'd0, quo_r[ax]};
        mul_b = {1'b0, apad};
      end
      default: begin
        mul_a = ad[ax];
        mul_b = ad[ax];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign sq_t  = res_r + {1'b0, bit_r};
  assign sq_ge = {2'd0, sq_rem_r} >= sq_t;

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        ctr_r[i] <= '0;
      end
    end else begin
      // In S_OUT the output register is refilled whenever it is free.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_item.op)
              msp_pkg::OP_ACC, msp_pkg::OP_ACC_LAST: begin
                if (cnt_room) begin
                  for (int i = 0; i < 3; i++) begin
                    sum_r[i] <= sum_r[i] + {{16{in_c[i][31]}}, in_c[i]};
                  end
                  cnt_r <= cnt_inc;
                end
                // The count is never zero after a vertex, so a last mark
                // always latches a new centroid.
                if (q_item.op == msp_pkg::OP_ACC_LAST) begin
                  state_r <= S_CLOAD;
                end
              end
              msp_pkg::OP_XFORM: begin
                for (int i = 0; i < 3; i++) begin
                  d_r[i] <= {in_c[i][31], in_c[i]} - {ctr_r[i][31], ctr_r[i]};
                end
                state_r <= S_DIFF;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIFF: begin
          if (d_r[0] == '0 && d_r[1] == '0 && d_r[2] == '0) begin
            o_r.x_out     <= msp_pkg::sat32(50'(ctr_r[0]) - 50'(pad));
            o_r.y_out     <= msp_pkg::sat32(50'(ctr_r[1]) - 50'(pad));
            o_r.z_out     <= msp_pkg::sat32(50'(ctr_r[2]) - 50'(pad));
            o_r.at_center <= 1'b1;
            state_r       <= S_OUT;
          end else begin
            acc_r   <= '0;
            step_r  <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_r != '0) begin
            acc_r <= acc_r + mul_r;
          end
          if (step_r[1:0] == 2'd3) begin
            sq_rem_r <= acc_r + mul_r;
            res_r    <= '0;
            bit_r    <= {1'b1, 66'd0};
            step_r   <= '0;
            state_r  <= S_SQRT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_rem_r <= 66'({2'd0, sq_rem_r} - sq_t);
            res_r    <= (res_r >> 1) + {1'b0, bit_r};
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (step_r == 6'd33) begin
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DIV: begin
          if (step_r == '0) begin
            // Offset length is at least one for a nonzero offset.
            norm_r <= res_r[33:0];
            for (int i = 0; i < 3; i++) begin
              drem_r[i] <= {2'd0, ad[i]};
              quo_r[i]  <= '0;
            end
            step_r <= step_r + 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (drem_r[i] >= {1'b0, norm_r}) begin
                drem_r[i] <= {34'(drem_r[i] - {1'b0, norm_r}), 1'b0};
                quo_r[i]  <= {quo_r[i][29:0], 1'b1};
              end else begin
                drem_r[i] <= {drem_r[i][33:0], 1'b0};
                quo_r[i]  <= {quo_r[i][29:0], 1'b0};
              end
            end
            if (step_r == 6'd31) begin
              step_r  <= '0;
              state_r <= S_MS;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_MS: begin
          if (step_r != '0) begin
            s_r[cx] <= 41'((mul_r + 66'h8000) >> 16);
          end
          if (step_r[1:0] == 2'd3) begin
            step_r  <= '0;
            state_r <= S_MP;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_MP: begin
          if (step_r != '0) begin
            p_r[cx] <= 33'((mul_r + 66'h2000_0000) >> 30);
          end
          if (step_r[1:0] == 2'd3) begin
            step_r  <= '0;
            state_r <= S_SUM;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SUM: begin
          o_r.x_out <= msp_pkg::sat32(50'(ctr_r[0])
              + (d_r[0][32] ? -50'(s_r[0]) : 50'(s_r[0]))
              + ((d_r[0][32] != pad[31]) ? -50'(p_r[0]) : 50'(p_r[0])));
          o_r.y_out <= msp_pkg::sat32(50'(ctr_r[1])
              + (d_r[1][32] ? -50'(s_r[1]) : 50'(s_r[1]))
              + ((d_r[1][32] != pad[31]) ? -50'(p_r[1]) : 50'(p_r[1])));
          o_r.z_out <= msp_pkg::sat32(50'(ctr_r[2])
              + (d_r[2][32] ? -50'(s_r[2]) : 50'(s_r[2]))
              + ((d_r[2][32] != pad[31]) ? -50'(p_r[2]) : 50'(p_r[2])));
          o_r.at_center <= 1'b0;
          state_r       <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= o_r;
            state_r     <= S_IDLE;
          end
        end
        S_CLOAD: begin
          for (int i = 0; i < 3; i++) begin
            cneg_r[i] <= sum_r[i][47];
            cdd_r[i]  <= {1'b0, (sum_r[i][47] ? 48'(-sum_r[i]) : sum_r[i])}
                         + 49'(cnt_r >> 1);
            crem_r[i] <= '0;
            cq_r[i]   <= '0;
            sum_r[i]  <= '0;
          end
          cdiv_r  <= cnt_r;
          cnt_r   <= '0;
          step_r  <= '0;
          state_r <= S_CDIV;
        end
        S_CDIV: begin
          for (int i = 0; i < 3; i++) begin
            if ({crem_r[i], cdd_r[i][48]} >= {1'b0, cdiv_r}) begin
              crem_r[i] <= CNT_W'({crem_r[i], cdd_r[i][48]} - {1'b0, cdiv_r});
              cq_r[i]   <= {cq_r[i][47:0], 1'b1};
            end else begin
              crem_r[i] <= CNT_W'({crem_r[i], cdd_r[i][48]});
              cq_r[i]   <= {cq_r[i][47:0], 1'b0};
            end
            cdd_r[i] <= {cdd_r[i][47:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == 6'd48) begin
            state_r <= S_CSAT;
          end
        end
        S_CSAT: begin
          for (int i = 0; i < 3; i++) begin
            ctr_r[i] <= msp_pkg::sat32(cneg_r[i] ? -$signed({1'b0, cq_r[i]})
                                                 : $signed({1'b0, cq_r[i]}));
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/msp_checker.sv
module msp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input msp_pkg::out_t out_data
);

  // A result only appears after the back part has run out of reset.
  a_rise_after_reset: assert property (@(posedge clk)
    $rose(out_valid) |-> $past(rst_n) && $past(rst_n, 2))
    else $error("result appeared too soon after reset");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind mesh_scale_and_pad msp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/mesh_scale_and_pad_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts every transform
// result and compares the results in order.
module mesh_scale_and_pad_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  msp_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  msp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata,
  output int            pending,
  output int            errors
);

  localparam int VERTEX_LIMIT = 65536;

  logic [23:0]        scale;
  logic signed [31:0] pad;
  logic [47:0]        sum_x, sum_y, sum_z;
  logic [16:0]        count;
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  msp_pkg::out_t      moved_q[$];

  initial errors = 0;
  assign pending = moved_q.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rounded mean, ties away from zero.
  function automatic logic [31:0] mean_of(logic [47:0] s, logic [16:0] n);
    longint sv;
    longint unsigned m, q;
    sv = longint'($signed(s));
    m = (sv < 0) ? longint'(-sv) : longint'(sv);
    q = (m + n / 2) / n;
    return 32'(clamp32((sv < 0) ? -longint'(q) : longint'(q)));
  endfunction

  function automatic longint unsigned root_floor(logic [127:0] rem);
    logic [127:0] res, probe;
    res = '0;
    probe = 128'd1 << 66;
    while (probe > rem && probe != 0) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res[63:0];
  endfunction

  function automatic logic [31:0] push_axis(longint c, longint d, longint unsigned len);
    longint unsigned ad, s, r, p, pm;
    longint v, pl;
    pl = longint'(pad);
    pm = (pl < 0) ? longint'(-pl) : longint'(pl);
    ad = (d < 0) ? longint'(-d) : longint'(d);
    s = (ad * scale + 64'd32768) >> 16;
    r = (ad << 30) / len;
    p = (r * pm + (64'd1 << 29)) >> 30;
    v = c + ((d < 0) ? -longint'(s) : longint'(s));
    v = v + (((d < 0) != (pl < 0)) ? -longint'(p) : longint'(p));
    return 32'(clamp32(v));
  endfunction

  function automatic msp_pkg::out_t move_vertex(msp_pkg::in_t it);
    msp_pkg::out_t o;
    longint dx, dy, dz, pl;
    longint unsigned ax, ay, az, len;
    logic [127:0] sq;
    dx = longint'($signed(it.x_in)) - longint'(ctr_x);
    dy = longint'($signed(it.y_in)) - longint'(ctr_y);
    dz = longint'($signed(it.z_in)) - longint'(ctr_z);
    pl = longint'(pad);
    if (dx == 0 && dy == 0 && dz == 0) begin
      o.x_out = 32'(clamp32(longint'(ctr_x) - pl));
      o.y_out = 32'(clamp32(longint'(ctr_y) - pl));
      o.z_out = 32'(clamp32(longint'(ctr_z) - pl));
      o.at_center = 1'b1;
    end else begin
      ax = (dx < 0) ? longint'(-dx) : longint'(dx);
      ay = (dy < 0) ? longint'(-dy) : longint'(dy);
      az = (dz < 0) ? longint'(-dz) : longint'(dz);
      sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
      len = root_floor(sq);
      if (len == 0) len = 1;
      o.x_out = push_axis(longint'(ctr_x), dx, len);
      o.y_out = push_axis(longint'(ctr_y), dy, len);
      o.z_out = push_axis(longint'(ctr_z), dz, len);
      o.at_center = 1'b0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scale = 24'd65536;
      pad = '0;
      sum_x = '0; sum_y = '0; sum_z = '0;
      count = '0;
      ctr_x = '0; ctr_y = '0; ctr_z = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == msp_pkg::REG_SCALE) scale = cfg_wdata[23:0];
        else pad = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        if (in_data.command) begin
          moved_q.push_back(move_vertex(in_data));
        end else begin
          if (count < VERTEX_LIMIT) begin
            sum_x = sum_x + {{16{in_data.x_in[31]}}, in_data.x_in};
            sum_y = sum_y + {{16{in_data.y_in[31]}}, in_data.y_in};
            sum_z = sum_z + {{16{in_data.z_in[31]}}, in_data.z_in};
            count = count + 1'b1;
          end
          if (in_data.last_vertex && count != 0) begin
            ctr_x = mean_of(sum_x, count);
            ctr_y = mean_of(sum_y, count);
            ctr_z = mean_of(sum_z, count);
            sum_x = '0; sum_y = '0; sum_z = '0;
            count = '0;
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (moved_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          msp_pkg::out_t e;
          e = moved_q.pop_front();
          if (e.x_out !== out_data.x_out || e.y_out !== out_data.y_out ||
              e.z_out !== out_data.z_out || e.at_center !== out_data.at_center) begin
            $display({"%0t: result differs, expected x=%h y=%h z=%h c=%b,",
                      " actual x=%h y=%h z=%h c=%b"},
                     $time, e.x_out, e.y_out, e.z_out, e.at_center,
                     out_data.x_out, out_data.y_out, out_data.z_out, out_data.at_center);
            errors++;
          end
        end
      end
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Drives meshes through the block in two passes (accumulate, then transform)
// under several scale and padding settings, while the checker predicts and
// compares every moved vertex.
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  // A last mark keeps the back part busy without a result, so wait this long
  // after the final result before touching the registers.
  localparam int SETTLE_CYCLES = 150;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  msp_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  msp_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic          cfg_index = msp_pkg::REG_SCALE;
  logic [31:0]   cfg_wdata = '0;

  int pending, errors;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  mesh_scale_and_pad DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  mesh_scale_and_pad_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .pending, .errors
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
  end

  // The run ends if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("mesh_scale_and_pad: mismatch");
        $finish;
      end
    end
  end

  // Presents one item and returns at the edge that accepts it. Valid stays
  // high into the next item unless the sender decides to idle first.
  task automatic send_item(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic last);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_data <= '{command: cmd, x_in: x, y_in: y, z_in: z, last_vertex: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Holds the sender back until every expected result has come out and the
  // back part has had time to finish any centroid division.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write, then the write enable is dropped before the task returns.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates mix full-range noise, small meshes and the extremes.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 2000)) - 32'd1000;
      2, 3: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      4: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0001;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // One mesh: the accumulate pass with the last mark on its final vertex,
  // then the transform pass over the same vertices. A few stray items are
  // mixed in so the broken cases get exercised too.
  task automatic run_mesh();
    logic [31:0] xs[8], ys[8], zs[8];
    int n;
    n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      xs[i] = pick_coord();
      ys[i] = pick_coord();
      zs[i] = pick_coord();
    end
    // Occasionally reuse a vertex so some transforms land on the centroid.
    if ($urandom_range(3) == 0) begin
      for (int i = 1; i < n; i++) begin
        xs[i] = xs[0]; ys[i] = ys[0]; zs[i] = zs[0];
      end
    end
    for (int i = 0; i < n; i++) begin
      send_item(1'b0, xs[i], ys[i], zs[i], i == n - 1);
    end
    for (int i = 0; i < n; i++) begin
      send_item(1'b1, xs[i], ys[i], zs[i], 1'($urandom_range(1)));
      if ($urandom_range(7) == 0) begin
        send_item(1'b1, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    logic [31:0] scale_set[4];
    logic [31:0] pad_set[4];
    int target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Before any latch the centroid is zero, so the origin
    // sits on it and a stray last mark on a transform must be ignored.
    send_item(1'b1, 32'h0, 32'h0, 32'h0, 1'b1);
    send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_item(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    wait_idle();
    write_reg(msp_pkg::REG_PAD, 32'h7FFF_FFFF);
    write_reg(msp_pkg::REG_SCALE, 32'h00FF_FFFF);
    // A single-vertex mesh at the positive extreme, then far points that
    // drive the outputs into saturation on both sides.
    send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_item(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_item(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(1'b1, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    wait_idle();
    write_reg(msp_pkg::REG_PAD, 32'h8000_0000);
    write_reg(msp_pkg::REG_SCALE, 32'h0);
    // Two vertices whose mean rounds away from zero on a tie.
    send_item(1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    send_item(1'b0, 32'hFFFF_FFFE, 32'h8000_0000, 32'h1, 1'b1);
    send_item(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 1'b0);
    send_item(1'b1, 32'hFFFF_FFFE, 32'h8000_0001, 32'h0, 1'b0);
    send_item(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

    // Random part: three idling phases, each through four settings.
    scale_set = '{32'h0001_0000, 32'h0, 32'h00FF_FFFF, 32'h0};
    pad_set   = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 49 : 0;
      rx_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 24 : 0;
      for (int k = 0; k < 4; k++) begin
        wait_idle();
        scale_set[3] = $urandom_range(0, 32'h0003_0000);
        pad_set[3] = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        write_reg(msp_pkg::REG_SCALE, scale_set[(k + phase) % 4]);
        write_reg(msp_pkg::REG_PAD, pad_set[k]);
        target = items_sent + 65;
        while (items_sent < target) begin
          run_mesh();
          // Once in a while the sender waits for the block to run dry.
          if (k == 1 && items_sent + 30 > target) begin
            wait_idle();
            target = target - 30;
          end
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("mesh_scale_and_pad: match");
    end else begin
      $display("mesh_scale_and_pad: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/msp_pkg.sv
rtl/core/msp_front.sv
rtl/core/msp_queue.sv
rtl/core/msp_back.sv
rtl/core/mesh_scale_and_pad.sv
rtl/core/msp_checker.sv
test/mesh_scale_and_pad_checker.sv
test/testbench.sv
